// ===== rtl/core/rvie_pkg.sv =====
package rvie_pkg;

	// Result status codes.
	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_HALT      = 4'd1;
	localparam logic [3:0] ST_PANIC     = 4'd2;
	localparam logic [3:0] ST_SYSCALL   = 4'd3;
	localparam logic [3:0] ST_BADOP     = 4'd4;
	localparam logic [3:0] ST_MEMFAULT  = 4'd5;
	localparam logic [3:0] ST_OVERFLOW  = 4'd6;
	localparam logic [3:0] ST_UNDERFLOW = 4'd7;
	localparam logic [3:0] ST_DIVZERO   = 4'd8;
	localparam logic [3:0] ST_BADREG    = 4'd9;

	// Opcodes.
	localparam logic [7:0] OP_HALT   = 8'h00;
	localparam logic [7:0] OP_PANIC  = 8'he0;
	localparam logic [7:0] OP_MOVE   = 8'hd0;
	localparam logic [7:0] OP_MOVEI  = 8'hd1;
	localparam logic [7:0] OP_MOVEIB = 8'hd2;
	localparam logic [7:0] OP_LOAD   = 8'hd3;
	localparam logic [7:0] OP_LOADB  = 8'hd4;
	localparam logic [7:0] OP_STORE  = 8'hd5;
	localparam logic [7:0] OP_STOREB = 8'hd6;
	localparam logic [7:0] OP_PUSH   = 8'hd7;
	localparam logic [7:0] OP_POP    = 8'hd8;
	localparam logic [7:0] OP_JUMP   = 8'hf0;
	localparam logic [7:0] OP_CJUMP  = 8'hf1;
	localparam logic [7:0] OP_CALL   = 8'hf2;
	localparam logic [7:0] OP_RET    = 8'hf3;
	localparam logic [7:0] OP_SYSC   = 8'hf4;
	localparam logic [7:0] OP_CMP    = 8'hc0;
	localparam logic [7:0] OP_ISEQ   = 8'hc1;
	localparam logic [7:0] OP_ISLT   = 8'hc2;
	localparam logic [7:0] OP_ISGT   = 8'hc3;
	localparam logic [7:0] OP_ISLE   = 8'hc4;
	localparam logic [7:0] OP_ISGE   = 8'hc5;
	localparam logic [7:0] OP_ADD    = 8'ha0;
	localparam logic [7:0] OP_SUB    = 8'ha1;
	localparam logic [7:0] OP_MUL    = 8'ha2;
	localparam logic [7:0] OP_DIV    = 8'ha3;
	localparam logic [7:0] OP_REM    = 8'ha4;
	localparam logic [7:0] OP_AND    = 8'hb0;
	localparam logic [7:0] OP_OR     = 8'hb1;
	localparam logic [7:0] OP_XOR    = 8'hb2;
	localparam logic [7:0] OP_NOT    = 8'hb3;

	// Register indexes with a fixed role.
	localparam logic [2:0] R_SP = 3'd0;
	localparam logic [2:0] R_ST = 3'd1;

	// Shared iterative unit operations.
	typedef enum logic [1:0] {
		ITER_MUL = 2'd0,
		ITER_DIV = 2'd1,
		ITER_REM = 2'd2
	} iter_op_t;

	// Start request toward the iterative unit, and busy and done status from it.
	typedef struct packed {
		logic     start;
		iter_op_t op;
	} iter_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} iter_stat_t;

endpackage

// ===== rtl/core/rvie_iter.sv =====
// Shared multi-cycle unit: a 64-bit shift-add multiplier and a restoring
// divider, one bit per cycle.
module rvie_iter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rvie_pkg::iter_req_t  req,
	input  logic [63:0]          opa,
	input  logic [63:0]          opb,
	output rvie_pkg::iter_stat_t stat,
	output logic [63:0]          result
);

	logic                 busy_q;
	logic                 done_q;
	logic [6:0]           cnt_q;
	rvie_pkg::iter_op_t   op_q;
	logic [63:0]          acc_q;
	logic [63:0]          a_q;
	logic [63:0]          b_q;
	logic [64:0]          trial;
	logic [63:0]          rem_sh;

	// One step of the restoring divider.
	assign rem_sh = {acc_q[62:0], a_q[63]};
	assign trial  = {acc_q[63], rem_sh} - {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers need no reset.
	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			acc_q <= '0;
			a_q   <= opa;
			b_q   <= opb;
		end else if (busy_q) begin
			if (op_q == rvie_pkg::ITER_MUL) begin
				acc_q <= (a_q[0] ? acc_q + b_q : acc_q);
				a_q   <= {1'b0, a_q[63:1]};
				b_q   <= {b_q[62:0], 1'b0};
			end else begin
				if (!trial[64]) begin
					acc_q <= trial[63:0];
					a_q   <= {a_q[62:0], 1'b1};
				end else begin
					acc_q <= rem_sh;
					a_q   <= {a_q[62:0], 1'b0};
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result = (op_q == rvie_pkg::ITER_DIV) ? a_q : acc_q;

endmodule

// ===== rtl/core/register_vm_instruction_executor_top.sv =====
// Channel | Direction | Handshake      | Payload
// in      | input     | valid / stall  | cmd, opcode, reg_byte, immediate, preload_*
// out     | output    | out_valid / out_stall | status, next_ip, syscall_number, reg_*
//
// Between two accepts, a preload, a simple instruction or an error passes
// through S_EXEC and S_OUT. A return adds S_RET; stores and push add S_MEM, loads
// and pop add S_RDW, one data memory byte per cycle. Multiply, divide and remainder
// add S_ITER, where they wait for the shared unit.
// Reset sets sp to MEM_BYTES and clears ip, the return depth and the control.
// Memories are not cleared. The block takes no item while one is in flight
// or its result waits under out_stall.
module register_vm_instruction_executor_top #(
	parameter int MEM_BYTES  = 65536,
	parameter int CALL_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  logic [0:0]  cmd,
	input  logic [7:0]  opcode,
	input  logic [7:0]  reg_byte,
	input  logic [63:0] immediate,
	input  logic [15:0] preload_address,
	input  logic [7:0]  preload_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  status,
	output logic [63:0] next_ip,
	output logic [7:0]  syscall_number,
	output logic [63:0] reg_a_value,
	output logic [63:0] reg_b_value,
	output logic [63:0] reg_c_value,
	output logic [63:0] status_register
);

	localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
	localparam int CW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
	localparam int DW = $clog2(CALL_DEPTH + 1);
	localparam logic [63:0] MEMSZ = 64'(MEM_BYTES);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_EXEC  = 7'b0000010,
		S_MEM   = 7'b0000100,
		S_RDW   = 7'b0001000,
		S_RET   = 7'b0010000,
		S_ITER  = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t       state_q;
	logic [63:0]  regs_q [8];
	logic [63:0]  pc_q;
	logic [DW-1:0] depth_q;
	logic [7:0]   dmem [MEM_BYTES];
	logic [63:0]  rstack [CALL_DEPTH];

	logic         cmd_q;
	logic [7:0]   op_q;
	logic [7:0]   rb_q;
	logic [63:0]  imm_q;
	logic [63:0]  dv_q;
	logic [63:0]  sv_q;
	logic [3:0]   stat_q;
	logic [7:0]   scn_q;

	// Memory walk.
	logic [63:0]  maddr_q;
	logic [63:0]  wdata_q;
	logic [3:0]   bcnt_q;
	logic         mwr_q;
	logic [3:0]   nbytes_q;
	logic [7:0]   rdbyte_q;
	logic [63:0]  rdata_q;
	logic [63:0]  rsdata_q;

	rvie_pkg::iter_req_t  ireq;
	rvie_pkg::iter_stat_t istat;
	logic [63:0]          ires;

	logic [2:0] d, s;
	logic       use_d, use_s;

	assign stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign d = rb_q[2:0];
	assign s = rb_q[6:4];

	// Operand use, for the bad register check.
	always_comb begin
		use_d = 1'b0;
		use_s = 1'b0;
		case (op_q)
			rvie_pkg::OP_MOVE, rvie_pkg::OP_LOAD, rvie_pkg::OP_LOADB, rvie_pkg::OP_STORE,
			rvie_pkg::OP_STOREB, rvie_pkg::OP_CMP, rvie_pkg::OP_ADD, rvie_pkg::OP_SUB,
			rvie_pkg::OP_MUL, rvie_pkg::OP_DIV, rvie_pkg::OP_REM, rvie_pkg::OP_AND,
			rvie_pkg::OP_OR, rvie_pkg::OP_XOR: begin
				use_d = 1'b1;
				use_s = 1'b1;
			end
			rvie_pkg::OP_MOVEI, rvie_pkg::OP_MOVEIB, rvie_pkg::OP_PUSH, rvie_pkg::OP_POP,
			rvie_pkg::OP_NOT: use_d = 1'b1;
			default: ;
		endcase
	end

	rvie_iter u_iter (
		.clk(clk), .arst_n(arst_n), .req(ireq), .opa(dv_q), .opb(sv_q),
		.stat(istat), .result(ires)
	);

	// Data memory: byte wide, one write port and one read port, read data registered.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && valid && cmd[0] && 32'(preload_address) < MEM_BYTES)
			dmem[AW'(preload_address)] <= preload_data;
		else if (state_q == S_MEM && mwr_q)
			dmem[maddr_q[AW-1:0]] <= wdata_q[7:0];
		rdbyte_q <= dmem[maddr_q[AW-1:0]];
	end

	// Return stack: written by call, read registered for ret.
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && cmd_q == 1'b0 && op_q == rvie_pkg::OP_CALL
				&& !(rb_q[3] && use_d) && 32'(depth_q) < CALL_DEPTH)
			rstack[depth_q[CW-1:0]] <= pc_q + 64'd9;
		rsdata_q <= rstack[CW'(depth_q - DW'(1))];
	end

	logic sneg;
	logic test;
	assign sneg = regs_q[rvie_pkg::R_ST][63];
	always_comb begin
		case (op_q)
			rvie_pkg::OP_ISEQ: test = (regs_q[rvie_pkg::R_ST] == 64'd0);
			rvie_pkg::OP_ISLT: test = sneg;
			rvie_pkg::OP_ISGT: test = !sneg && regs_q[rvie_pkg::R_ST] != 64'd0;
			rvie_pkg::OP_ISLE: test = sneg || regs_q[rvie_pkg::R_ST] == 64'd0;
			default:           test = !sneg;
		endcase
	end

	always_comb begin
		ireq.start = 1'b0;
		ireq.op    = rvie_pkg::ITER_MUL;
		if (state_q == S_EXEC && cmd_q == 1'b0 && !(rb_q[3] || rb_q[7])) begin
			if (op_q == rvie_pkg::OP_MUL) ireq.start = 1'b1;
			if ((op_q == rvie_pkg::OP_DIV || op_q == rvie_pkg::OP_REM) && sv_q != 64'd0) begin
				ireq.start = 1'b1;
				ireq.op = (op_q == rvie_pkg::OP_DIV) ? rvie_pkg::ITER_DIV : rvie_pkg::ITER_REM;
			end
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 1; i < 8; i++) regs_q[i] <= '0;
			regs_q[0] <= MEMSZ;
			pc_q <= '0;
			depth_q <= '0;
			bcnt_q <= '0;
			mwr_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (valid) begin
					cmd_q <= cmd[0];
					op_q <= opcode;
					rb_q <= reg_byte;
					imm_q <= immediate;
					dv_q <= regs_q[reg_byte[2:0]];
					sv_q <= regs_q[reg_byte[6:4]];
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					stat_q <= rvie_pkg::ST_OK;
					scn_q <= 8'd0;
					state_q <= S_OUT;
					if (cmd_q) begin
						stat_q <= rvie_pkg::ST_OK;
					end else if ((use_d && rb_q[3]) || (use_s && rb_q[7])) begin
						stat_q <= rvie_pkg::ST_BADREG;
					end else begin
						unique case (op_q)
							rvie_pkg::OP_HALT: stat_q <= rvie_pkg::ST_HALT;
							rvie_pkg::OP_PANIC: stat_q <= rvie_pkg::ST_PANIC;
							rvie_pkg::OP_MOVE: begin regs_q[d] <= sv_q; pc_q <= pc_q + 64'd2; end
							rvie_pkg::OP_MOVEI: begin regs_q[d] <= imm_q; pc_q <= pc_q + 64'd10; end
							rvie_pkg::OP_MOVEIB: begin
								regs_q[d] <= {56'd0, imm_q[7:0]};
								pc_q <= pc_q + 64'd3;
							end
							rvie_pkg::OP_LOAD, rvie_pkg::OP_POP: begin
								if (op_q == rvie_pkg::OP_LOAD ? (sv_q > MEMSZ - 64'd8)
										: (regs_q[0] > MEMSZ - 64'd8))
									stat_q <= (op_q == rvie_pkg::OP_LOAD) ? rvie_pkg::ST_MEMFAULT
										: rvie_pkg::ST_UNDERFLOW;
								else begin
									maddr_q <= (op_q == rvie_pkg::OP_LOAD) ? sv_q : regs_q[0];
									mwr_q <= 1'b0; nbytes_q <= 4'd8; bcnt_q <= 4'd0;
									state_q <= S_RDW;
								end
							end
							rvie_pkg::OP_LOADB: begin
								if (sv_q >= MEMSZ) stat_q <= rvie_pkg::ST_MEMFAULT;
								else begin
									maddr_q <= sv_q; mwr_q <= 1'b0; nbytes_q <= 4'd1;
									bcnt_q <= 4'd0; state_q <= S_RDW;
								end
							end
							rvie_pkg::OP_STORE: begin
								if (dv_q > MEMSZ - 64'd8) stat_q <= rvie_pkg::ST_MEMFAULT;
								else begin
									maddr_q <= dv_q; wdata_q <= sv_q; mwr_q <= 1'b1;
									nbytes_q <= 4'd8; bcnt_q <= 4'd0; state_q <= S_MEM;
								end
							end
							rvie_pkg::OP_STOREB: begin
								if (dv_q >= MEMSZ) stat_q <= rvie_pkg::ST_MEMFAULT;
								else begin
									maddr_q <= dv_q; wdata_q <= sv_q; mwr_q <= 1'b1;
									nbytes_q <= 4'd1; bcnt_q <= 4'd0; state_q <= S_MEM;
								end
							end
							rvie_pkg::OP_PUSH: begin
								if (regs_q[0] < 64'd8) stat_q <= rvie_pkg::ST_OVERFLOW;
								else if (regs_q[0] > MEMSZ) stat_q <= rvie_pkg::ST_MEMFAULT;
								else begin
									regs_q[0] <= regs_q[0] - 64'd8;
									maddr_q <= regs_q[0] - 64'd8;
									wdata_q <= (d == rvie_pkg::R_SP) ? regs_q[0] - 64'd8 : dv_q;
									mwr_q <= 1'b1; nbytes_q <= 4'd8; bcnt_q <= 4'd0;
									state_q <= S_MEM;
								end
							end
							rvie_pkg::OP_JUMP: pc_q <= imm_q;
							rvie_pkg::OP_CJUMP:
								pc_q <= (regs_q[rvie_pkg::R_ST] != 64'd0) ? imm_q : pc_q + 64'd9;
							rvie_pkg::OP_CALL: begin
								if (32'(depth_q) >= CALL_DEPTH) stat_q <= rvie_pkg::ST_OVERFLOW;
								else begin depth_q <= depth_q + DW'(1); pc_q <= imm_q; end
							end
							rvie_pkg::OP_RET: begin
								if (depth_q == '0) stat_q <= rvie_pkg::ST_UNDERFLOW;
								else state_q <= S_RET;
							end
							rvie_pkg::OP_SYSC: begin
								stat_q <= rvie_pkg::ST_SYSCALL; scn_q <= rb_q;
								pc_q <= pc_q + 64'd2;
							end
							rvie_pkg::OP_CMP: begin
								regs_q[rvie_pkg::R_ST] <= dv_q - sv_q; pc_q <= pc_q + 64'd2;
							end
							rvie_pkg::OP_ISEQ, rvie_pkg::OP_ISLT, rvie_pkg::OP_ISGT,
							rvie_pkg::OP_ISLE, rvie_pkg::OP_ISGE: begin
								regs_q[rvie_pkg::R_ST] <= {63'd0, test}; pc_q <= pc_q + 64'd1;
							end
							rvie_pkg::OP_ADD: begin regs_q[d] <= dv_q + sv_q; pc_q <= pc_q + 64'd2; end
							rvie_pkg::OP_SUB: begin regs_q[d] <= dv_q - sv_q; pc_q <= pc_q + 64'd2; end
							rvie_pkg::OP_MUL: state_q <= S_ITER;
							rvie_pkg::OP_DIV, rvie_pkg::OP_REM: begin
								if (sv_q == 64'd0) stat_q <= rvie_pkg::ST_DIVZERO;
								else state_q <= S_ITER;
							end
							rvie_pkg::OP_AND: begin regs_q[d] <= dv_q & sv_q; pc_q <= pc_q + 64'd2; end
							rvie_pkg::OP_OR:  begin regs_q[d] <= dv_q | sv_q; pc_q <= pc_q + 64'd2; end
							rvie_pkg::OP_XOR: begin regs_q[d] <= dv_q ^ sv_q; pc_q <= pc_q + 64'd2; end
							rvie_pkg::OP_NOT: begin regs_q[d] <= ~dv_q; pc_q <= pc_q + 64'd2; end
							default: stat_q <= rvie_pkg::ST_BADOP;
						endcase
					end
				end
				// Byte writes, one per cycle.
				S_MEM: begin
					wdata_q <= {8'd0, wdata_q[63:8]};
					maddr_q <= maddr_q + 64'd1;
					bcnt_q <= bcnt_q + 4'd1;
					if (bcnt_q == nbytes_q - 4'd1) begin
						pc_q <= pc_q + 64'd2;
						state_q <= S_OUT;
					end
				end
				// Byte reads: address this cycle, data the next.
				S_RDW: begin
					maddr_q <= maddr_q + 64'd1;
					bcnt_q <= bcnt_q + 4'd1;
					if (bcnt_q != 4'd0)
						rdata_q <= {rdbyte_q, rdata_q[63:8]};
					if (bcnt_q == nbytes_q) begin
						if (nbytes_q == 4'd1) regs_q[d] <= {56'd0, rdbyte_q};
						else if (op_q == rvie_pkg::OP_POP && d == rvie_pkg::R_SP)
							regs_q[0] <= {rdbyte_q, rdata_q[63:8]} + 64'd8;
						else begin
							regs_q[d] <= {rdbyte_q, rdata_q[63:8]};
							if (op_q == rvie_pkg::OP_POP) regs_q[0] <= regs_q[0] + 64'd8;
						end
						pc_q <= pc_q + 64'd2;
						state_q <= S_OUT;
					end
				end
				S_RET: begin
					depth_q <= depth_q - DW'(1);
					pc_q <= rsdata_q;
					state_q <= S_OUT;
				end
				S_ITER: if (istat.done) begin
					regs_q[d] <= ires;
					pc_q <= pc_q + 64'd2;
					state_q <= S_OUT;
				end
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign status = stat_q;
	assign next_ip = pc_q;
	assign syscall_number = scn_q;
	assign reg_a_value = regs_q[2];
	assign reg_b_value = regs_q[3];
	assign reg_c_value = regs_q[4];
	assign status_register = regs_q[rvie_pkg::R_ST];

`ifndef NO_ASSERTIONS
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		32'(depth_q) <= CALL_DEPTH) else $error("return depth beyond capacity");
	a_iter: assert property (@(posedge clk) disable iff (!arst_n)
		istat.done |-> state_q == S_ITER) else $error("iterative result unused");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> stall) else $error("input taken while result pending");
`endif

endmodule

// ===== verif/register_vm_instruction_executor_checker.sv =====
`timescale 1ns / 1ps

module register_vm_instruction_executor_checker #(
	parameter int MEM_BYTES  = 65536,
	parameter int CALL_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	input  logic        stall,
	input  logic [0:0]  cmd,
	input  logic [7:0]  opcode,
	input  logic [7:0]  reg_byte,
	input  logic [63:0] immediate,
	input  logic [15:0] preload_address,
	input  logic [7:0]  preload_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [3:0]  status,
	input  logic [63:0] next_ip,
	input  logic [7:0]  syscall_number,
	input  logic [63:0] reg_a_value,
	input  logic [63:0] reg_b_value,
	input  logic [63:0] reg_c_value,
	input  logic [63:0] status_register,
	output int          errors,
	output int          pending
);

	typedef struct {
		logic [3:0]  status;
		logic [63:0] next_ip;
		logic [7:0]  sysnum;
		logic [63:0] reg_a;
		logic [63:0] reg_b;
		logic [63:0] reg_c;
		logic [63:0] reg_st;
	} machine_result_t;

	// Machine state as the predictor sees it; the stimulus side reads it too.
	logic [63:0] regs [8];
	logic [63:0] ip;
	logic [63:0] ret_stack [CALL_DEPTH];
	int          depth;
	logic [7:0]  mem [MEM_BYTES];
	bit          written [MEM_BYTES];

	machine_result_t results_q [$];

	initial begin
		errors = 0;
		pending = 0;
	end

	function automatic bit word_fits(logic [63:0] addr);
		return addr <= 64'(MEM_BYTES - 8);
	endfunction

	function automatic logic [63:0] read_word(logic [63:0] addr);
		logic [63:0] v;
		v = '0;
		for (int i = 7; i >= 0; i--)
			v = {v[55:0], mem[int'(addr) + i]};
		return v;
	endfunction

	function automatic void write_word(logic [63:0] addr, logic [63:0] v);
		for (int i = 0; i < 8; i++) begin
			mem[int'(addr) + i] = v[8*i +: 8];
			written[int'(addr) + i] = 1'b1;
		end
	endfunction

	function automatic bit st_test(logic [7:0] op, logic [63:0] st);
		bit neg;
		neg = st[63];
		case (op)
			rvie_pkg::OP_ISEQ: return st == 0;
			rvie_pkg::OP_ISLT: return neg;
			rvie_pkg::OP_ISGT: return !neg && st != 0;
			rvie_pkg::OP_ISLE: return neg || st == 0;
			default: return !neg;
		endcase
	endfunction

	// Executes one instruction on the predicted state; errors leave it untouched.
	function automatic logic [3:0] execute(logic [7:0] op, logic [7:0] rb, logic [63:0] imm);
		logic [3:0]  d;
		logic [3:0]  s;
		logic [2:0]  di;
		logic [2:0]  si;
		bit          use_d;
		bit          use_s;
		logic [63:0] nip;
		d = rb[3:0];
		s = rb[7:4];
		nip = ip;
		use_d = 0;
		use_s = 0;
		case (op)
			rvie_pkg::OP_MOVE, rvie_pkg::OP_LOAD, rvie_pkg::OP_LOADB, rvie_pkg::OP_STORE,
			rvie_pkg::OP_STOREB, rvie_pkg::OP_CMP, rvie_pkg::OP_ADD, rvie_pkg::OP_SUB,
			rvie_pkg::OP_MUL, rvie_pkg::OP_DIV, rvie_pkg::OP_REM, rvie_pkg::OP_AND,
			rvie_pkg::OP_OR, rvie_pkg::OP_XOR: begin
				use_d = 1;
				use_s = 1;
			end
			rvie_pkg::OP_MOVEI, rvie_pkg::OP_MOVEIB, rvie_pkg::OP_PUSH, rvie_pkg::OP_POP,
			rvie_pkg::OP_NOT: use_d = 1;
			default: ;
		endcase
		if ((use_d && d > 7) || (use_s && s > 7))
			return rvie_pkg::ST_BADREG;
		di = d[2:0];
		si = s[2:0];
		case (op)
			rvie_pkg::OP_HALT: return rvie_pkg::ST_HALT;
			rvie_pkg::OP_PANIC: return rvie_pkg::ST_PANIC;
			rvie_pkg::OP_MOVE: begin
				regs[di] = regs[si];
				nip += 2;
			end
			rvie_pkg::OP_MOVEI: begin
				regs[di] = imm;
				nip += 10;
			end
			rvie_pkg::OP_MOVEIB: begin
				regs[di] = {56'd0, imm[7:0]};
				nip += 3;
			end
			rvie_pkg::OP_LOAD: begin
				if (!word_fits(regs[si]))
					return rvie_pkg::ST_MEMFAULT;
				regs[di] = read_word(regs[si]);
				nip += 2;
			end
			rvie_pkg::OP_LOADB: begin
				if (regs[si] >= 64'(MEM_BYTES))
					return rvie_pkg::ST_MEMFAULT;
				regs[di] = {56'd0, mem[int'(regs[si])]};
				nip += 2;
			end
			rvie_pkg::OP_STORE: begin
				if (!word_fits(regs[di]))
					return rvie_pkg::ST_MEMFAULT;
				write_word(regs[di], regs[si]);
				nip += 2;
			end
			rvie_pkg::OP_STOREB: begin
				if (regs[di] >= 64'(MEM_BYTES))
					return rvie_pkg::ST_MEMFAULT;
				mem[int'(regs[di])] = regs[si][7:0];
				written[int'(regs[di])] = 1'b1;
				nip += 2;
			end
			rvie_pkg::OP_PUSH: begin
				if (regs[rvie_pkg::R_SP] < 8)
					return rvie_pkg::ST_OVERFLOW;
				if (regs[rvie_pkg::R_SP] > 64'(MEM_BYTES))
					return rvie_pkg::ST_MEMFAULT;
				// The pushed value is read after sp is lowered.
				regs[rvie_pkg::R_SP] -= 8;
				write_word(regs[rvie_pkg::R_SP], regs[di]);
				nip += 2;
			end
			rvie_pkg::OP_POP: begin
				logic [63:0] sp;
				sp = regs[rvie_pkg::R_SP];
				if (sp > 64'(MEM_BYTES - 8))
					return rvie_pkg::ST_UNDERFLOW;
				regs[di] = read_word(sp);
				regs[rvie_pkg::R_SP] += 8;
				nip += 2;
			end
			rvie_pkg::OP_JUMP: nip = imm;
			rvie_pkg::OP_CJUMP: nip = (regs[rvie_pkg::R_ST] != 0) ? imm : nip + 9;
			rvie_pkg::OP_CALL: begin
				if (depth >= CALL_DEPTH)
					return rvie_pkg::ST_OVERFLOW;
				ret_stack[depth] = nip + 9;
				depth++;
				nip = imm;
			end
			rvie_pkg::OP_RET: begin
				if (depth == 0)
					return rvie_pkg::ST_UNDERFLOW;
				depth--;
				nip = ret_stack[depth];
			end
			rvie_pkg::OP_SYSC: begin
				ip = nip + 2;
				return rvie_pkg::ST_SYSCALL;
			end
			rvie_pkg::OP_CMP: begin
				regs[rvie_pkg::R_ST] = regs[di] - regs[si];
				nip += 2;
			end
			rvie_pkg::OP_ISEQ, rvie_pkg::OP_ISLT, rvie_pkg::OP_ISGT, rvie_pkg::OP_ISLE,
			rvie_pkg::OP_ISGE: begin
				regs[rvie_pkg::R_ST] = st_test(op, regs[rvie_pkg::R_ST]) ? 64'd1 : 64'd0;
				nip += 1;
			end
			rvie_pkg::OP_ADD: begin
				regs[di] += regs[si];
				nip += 2;
			end
			rvie_pkg::OP_SUB: begin
				regs[di] -= regs[si];
				nip += 2;
			end
			rvie_pkg::OP_MUL: begin
				regs[di] *= regs[si];
				nip += 2;
			end
			rvie_pkg::OP_DIV: begin
				if (regs[si] == 0)
					return rvie_pkg::ST_DIVZERO;
				regs[di] /= regs[si];
				nip += 2;
			end
			rvie_pkg::OP_REM: begin
				if (regs[si] == 0)
					return rvie_pkg::ST_DIVZERO;
				regs[di] %= regs[si];
				nip += 2;
			end
			rvie_pkg::OP_AND: begin
				regs[di] &= regs[si];
				nip += 2;
			end
			rvie_pkg::OP_OR: begin
				regs[di] |= regs[si];
				nip += 2;
			end
			rvie_pkg::OP_XOR: begin
				regs[di] ^= regs[si];
				nip += 2;
			end
			rvie_pkg::OP_NOT: begin
				regs[di] = ~regs[di];
				nip += 2;
			end
			default: return rvie_pkg::ST_BADOP;
		endcase
		ip = nip;
		return rvie_pkg::ST_OK;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		if (errors < 40)
			$display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
		errors++;
	endtask

	// Predict on each accepted item, compare each accepted result with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		machine_result_t r;
		machine_result_t w;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				regs[i] = '0;
			regs[rvie_pkg::R_SP] = 64'(MEM_BYTES);
			ip = '0;
			depth = 0;
			results_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (results_q.size() == 0) begin
					report_mismatch("unexpected result, status", 64'(status), '0);
				end else begin
					w = results_q.pop_front();
					if (status !== w.status)
						report_mismatch("status", 64'(status), 64'(w.status));
					if (next_ip !== w.next_ip)
						report_mismatch("next_ip", next_ip, w.next_ip);
					if (syscall_number !== w.sysnum)
						report_mismatch("syscall_number", 64'(syscall_number), 64'(w.sysnum));
					if (reg_a_value !== w.reg_a)
						report_mismatch("reg_a_value", reg_a_value, w.reg_a);
					if (reg_b_value !== w.reg_b)
						report_mismatch("reg_b_value", reg_b_value, w.reg_b);
					if (reg_c_value !== w.reg_c)
						report_mismatch("reg_c_value", reg_c_value, w.reg_c);
					if (status_register !== w.reg_st)
						report_mismatch("status_register", status_register, w.reg_st);
				end
			end
			if (valid && !stall) begin
				r.status = rvie_pkg::ST_OK;
				if (cmd[0]) begin
					if (int'(preload_address) < MEM_BYTES) begin
						mem[preload_address] = preload_data;
						written[preload_address] = 1'b1;
					end
				end else begin
					r.status = execute(opcode, reg_byte, immediate);
				end
				r.next_ip = ip;
				r.sysnum = (r.status == rvie_pkg::ST_SYSCALL) ? reg_byte : 8'd0;
				r.reg_a = regs[2];
				r.reg_b = regs[3];
				r.reg_c = regs[4];
				r.reg_st = regs[rvie_pkg::R_ST];
				results_q.push_back(r);
			end
		end
		pending = results_q.size();
	end

endmodule

// ===== verif/tb_register_vm_instruction_executor_top.sv =====
`timescale 1ns / 1ps

module tb_register_vm_instruction_executor_top;

	localparam int MEM_BYTES  = 65536;
	localparam int CALL_DEPTH = 1024;
	localparam int RANDOM_ITEMS = 1100;
	localparam int CYCLE_LIMIT = 1500000;

	logic        clk;
	logic        arst_n;
	logic        valid;
	logic        stall;
	logic [0:0]  cmd;
	logic [7:0]  opcode;
	logic [7:0]  reg_byte;
	logic [63:0] immediate;
	logic [15:0] preload_address;
	logic [7:0]  preload_data;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  status;
	logic [63:0] next_ip;
	logic [7:0]  syscall_number;
	logic [63:0] reg_a_value;
	logic [63:0] reg_b_value;
	logic [63:0] reg_c_value;
	logic [63:0] status_register;
	int          errors;
	int          pending;
	int          cycles;
	int          burst_left;

	logic [7:0] op_list [$] = '{rvie_pkg::OP_HALT, rvie_pkg::OP_PANIC, rvie_pkg::OP_MOVE,
		rvie_pkg::OP_MOVEI, rvie_pkg::OP_MOVEIB, rvie_pkg::OP_LOAD, rvie_pkg::OP_LOADB,
		rvie_pkg::OP_STORE, rvie_pkg::OP_STOREB, rvie_pkg::OP_PUSH, rvie_pkg::OP_POP,
		rvie_pkg::OP_JUMP, rvie_pkg::OP_CJUMP, rvie_pkg::OP_CALL, rvie_pkg::OP_RET,
		rvie_pkg::OP_SYSC, rvie_pkg::OP_CMP, rvie_pkg::OP_ISEQ, rvie_pkg::OP_ISLT,
		rvie_pkg::OP_ISGT, rvie_pkg::OP_ISLE, rvie_pkg::OP_ISGE, rvie_pkg::OP_ADD,
		rvie_pkg::OP_SUB, rvie_pkg::OP_MUL, rvie_pkg::OP_DIV, rvie_pkg::OP_REM,
		rvie_pkg::OP_AND, rvie_pkg::OP_OR, rvie_pkg::OP_XOR, rvie_pkg::OP_NOT};

	register_vm_instruction_executor_top #(
		.MEM_BYTES(MEM_BYTES),
		.CALL_DEPTH(CALL_DEPTH)
	) dut (.*);

	register_vm_instruction_executor_checker #(
		.MEM_BYTES(MEM_BYTES),
		.CALL_DEPTH(CALL_DEPTH)
	) chk (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_register_vm_instruction_executor_top: FAIL");
			$finish;
		end
	end

	// The result side stalls on a pattern of its own: free, light, then heavy.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (cycles % 1024 < 300) begin
			out_stall <= 1'b0;
		end else if (cycles % 1024 < 700) begin
			out_stall <= ($urandom_range(0, 2) == 0);
		end else begin
			out_stall <= ($urandom_range(0, 7) != 0);
		end
	end

	// Presents one item, holds it until taken, then idles as the burst dictates.
	// The wait after the item is taken lets the predicted state settle before the next item is chosen.
	task automatic send_item(bit c, logic [7:0] op, logic [7:0] rb, logic [63:0] imm,
		logic [15:0] pa, logic [7:0] pd);
		valid <= 1'b1;
		cmd <= c;
		opcode <= op;
		reg_byte <= rb;
		immediate <= imm;
		preload_address <= pa;
		preload_data <= pd;
		@(posedge clk);
		while (stall)
			@(posedge clk);
		valid <= 1'b0;
		@(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			repeat ($urandom_range(0, 12))
				@(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
	endtask

	task automatic exec_item(logic [7:0] op, logic [7:0] rb, logic [63:0] imm);
		send_item(1'b0, op, rb, imm, 16'($urandom), 8'($urandom));
	endtask

	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2: return 64'($urandom_range(0, 300));
			3, 4: return 64'($urandom_range(MEM_BYTES - 40, MEM_BYTES + 8));
			5: return '0;
			6: return '1;
			7: return 64'h8000_0000_0000_0000;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [7:0] pick_regs();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom);
		return {1'b0, 3'($urandom), 1'b0, 3'($urandom)};
	endfunction

	// First byte that the instruction would read but that was never written, or -1.
	function automatic int unwritten_read(logic [7:0] op, logic [7:0] rb);
		logic [63:0] base;
		int          cnt;
		cnt = 0;
		base = '0;
		if (rb[3] == 1'b0) begin
			if (op == rvie_pkg::OP_LOAD && rb[7] == 1'b0
				&& chk.regs[rb[6:4]] <= 64'(MEM_BYTES - 8)) begin
				base = chk.regs[rb[6:4]];
				cnt = 8;
			end else if (op == rvie_pkg::OP_LOADB && rb[7] == 1'b0
				&& chk.regs[rb[6:4]] < 64'(MEM_BYTES)) begin
				base = chk.regs[rb[6:4]];
				cnt = 1;
			end else if (op == rvie_pkg::OP_POP
				&& chk.regs[rvie_pkg::R_SP] <= 64'(MEM_BYTES - 8)) begin
				base = chk.regs[rvie_pkg::R_SP];
				cnt = 8;
			end
		end
		for (int i = 0; i < cnt; i++)
			if (!chk.written[int'(base) + i])
				return int'(base) + i;
		return -1;
	endfunction

	task automatic random_item();
		logic [7:0]  op;
		logic [7:0]  rb;
		logic [15:0] pa;
		int          k;
		int          hole;
		k = $urandom_range(0, 99);
		if (k < 14) begin
			case ($urandom_range(0, 2))
				0: pa = 16'($urandom_range(0, 300));
				1: pa = 16'($urandom_range(MEM_BYTES - 64, MEM_BYTES - 1));
				default: pa = 16'($urandom);
			endcase
			send_item(1'b1, 8'($urandom), 8'($urandom), {$urandom, $urandom}, pa,
				8'($urandom));
		end else begin
			if (k < 24)
				op = rvie_pkg::OP_MOVEI;
			else if (k < 27)
				op = 8'($urandom);
			else
				op = op_list[$urandom_range(0, op_list.size() - 1)];
			rb = pick_regs();
			hole = unwritten_read(op, rb);
			if (hole >= 0)
				send_item(1'b1, op, rb, '0, 16'(hole), 8'($urandom));
			else
				exec_item(op, rb, pick_value());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		valid = 1'b0;
		cmd = '0;
		opcode = '0;
		reg_byte = '0;
		immediate = '0;
		preload_address = '0;
		preload_data = '0;
		cycles = 0;
		burst_left = 4;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, memory, stack and error cases.
		send_item(1'b1, rvie_pkg::OP_HALT, 8'h00, '0, 16'h0000, 8'hff);
		send_item(1'b1, rvie_pkg::OP_HALT, 8'hff, '1, 16'hffff, 8'h00);
		exec_item(rvie_pkg::OP_MOVEI, 8'h02, 64'd0);
		exec_item(rvie_pkg::OP_MOVEI, 8'h03, '1);
		exec_item(rvie_pkg::OP_MOVEIB, 8'h04, 64'hffff_ffff_ffff_ff34);
		exec_item(rvie_pkg::OP_STORE, 8'h32, '0);
		exec_item(rvie_pkg::OP_LOAD, 8'h25, '0);
		exec_item(rvie_pkg::OP_LOADB, 8'h26, '0);
		exec_item(rvie_pkg::OP_PUSH, 8'h03, '0);
		exec_item(rvie_pkg::OP_POP, 8'h07, '0);
		exec_item(rvie_pkg::OP_POP, 8'h07, '0);
		exec_item(rvie_pkg::OP_MOVE, 8'h8f, '0);
		exec_item(rvie_pkg::OP_DIV, 8'h23, '0);
		exec_item(rvie_pkg::OP_REM, 8'h43, '0);
		exec_item(rvie_pkg::OP_MUL, 8'h34, '0);
		exec_item(rvie_pkg::OP_CMP, 8'h43, '0);
		exec_item(rvie_pkg::OP_ISLT, 8'h00, '0);
		exec_item(rvie_pkg::OP_MOVEI, 8'h00, 64'd4);
		exec_item(rvie_pkg::OP_PUSH, 8'h02, '0);
		exec_item(rvie_pkg::OP_MOVEI, 8'h00, 64'h8000_0000_0000_0000);
		exec_item(rvie_pkg::OP_PUSH, 8'h02, '0);
		exec_item(rvie_pkg::OP_MOVEI, 8'h00, 64'(MEM_BYTES));
		exec_item(rvie_pkg::OP_SYSC, 8'hff, '0);
		exec_item(rvie_pkg::OP_CALL, 8'h00, 64'h0000_0000_0000_1234);
		exec_item(rvie_pkg::OP_RET, 8'h00, '0);
		exec_item(rvie_pkg::OP_RET, 8'h00, '0);
		exec_item(8'h01, 8'h00, '0);
		exec_item(rvie_pkg::OP_HALT, 8'h00, '0);
		exec_item(rvie_pkg::OP_PANIC, 8'h00, '0);
		exec_item(rvie_pkg::OP_CJUMP, 8'h00, 64'h0123_4567_89ab_cdef);
		exec_item(rvie_pkg::OP_JUMP, 8'h00, '1);

		// Random traffic, with one full drain in the middle.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2)
				while (pending != 0)
					@(posedge clk);
			random_item();
		end

		while (pending != 0)
			@(posedge clk);
		repeat (100)
			@(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_register_vm_instruction_executor_top: PASS");
		else
			$display("tb_register_vm_instruction_executor_top: FAIL");
		$finish;
	end

endmodule
